[src/multi_pattern_byte_matcher_top_assert.svh]
// Assertion macros for the multi-pattern byte matcher.
// Needs a clock and an active-low reset in the scope that uses them.
`ifndef MULTI_PATTERN_BYTE_MATCHER_TOP_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define MPBM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPBM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mpbm_pkg.sv]
// Package for the multi-pattern byte matcher: sizes, word types, codes
// and the upper-casing helper. No dependencies.
package mpbm_pkg;

    localparam int ENTRIES = 8;
    localparam int MAX_LEN = 32;

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (ENTRIES * MAX_LEN > 1) ? $clog2(ENTRIES * MAX_LEN) : 1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [15:0]       key_t;
    typedef logic [7:0]        char_t;
    typedef logic [2:0]        status_t;
    typedef logic [1:0]        cmd_t;

    localparam cmd_t CMD_MATCH  = 2'd0;
    localparam cmd_t CMD_LOAD   = 2'd1;
    localparam cmd_t CMD_DELETE = 2'd2;
    localparam cmd_t CMD_CLEAR  = 2'd3;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_IGNORED   = 3'd1;
    localparam status_t ST_DUPLICATE = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_TOO_LONG  = 3'd4;
    localparam status_t ST_NOT_FOUND = 3'd5;

    typedef struct packed {
        cmd_t  cmd;
        key_t  key;
        char_t data_byte;
        logic  last;
    } mpbm_in_t;

    typedef struct packed {
        logic    matched;
        key_t    match_key;
        status_t status;
    } mpbm_out_t;

    function automatic char_t upcase(char_t c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic addr_t char_addr(slot_t s, len_t off);
        return ADDR_W'(int'(s) * MAX_LEN + int'(off));
    endfunction

endpackage

[src/multi_pattern_byte_matcher_top.sv]
// Multi-pattern byte matcher. Load, delete and clear words are handled in idle; a
// match word sweeps the table when any pattern is stored and skips the sweep when the
// table is empty. The sweep issues one pattern character memory read per table entry
// and compares each entry against the registered read data. Results go to an output
// register, so the next word is taken while the last result waits. No clearing pass
// after reset.
// Depends on mpbm_pkg and mpbm_core.
module multi_pattern_byte_matcher_top
    import mpbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mpbm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mpbm_out_t m_data
);

    logic      res_valid, res_ready;
    mpbm_out_t res_data;
    logic      out_valid_reg;
    mpbm_out_t out_data_reg;

    mpbm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_data_reg <= res_data;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[src/mpbm_char_ram.sv]
// Pattern character memory: one write port, one read port, registered read.
// Depends on mpbm_pkg.
module mpbm_char_ram
    import mpbm_pkg::*;
(
    input  logic  aclk,
    input  logic  we,
    input  addr_t waddr,
    input  char_t wdata,
    input  logic  re,
    input  addr_t raddr,
    output char_t rdata
);

    char_t mem [ENTRIES * MAX_LEN];
    char_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/mpbm_core.sv]
// Matcher core: pattern table, load/delete/clear handling and the match sweep
// over the character memory. Depends on mpbm_pkg and mpbm_char_ram.
module mpbm_core
    import mpbm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  mpbm_in_t  in_data,
    output logic      res_valid,
    input  logic      res_ready,
    output mpbm_out_t res_data
);

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DONE} state_t;

    localparam slot_t LAST_SLOT = SLOT_W'(ENTRIES - 1);

    state_t    state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    key_t      key_reg   [ENTRIES];
    key_t      key_next  [ENTRIES];
    len_t      len_reg   [ENTRIES];
    len_t      len_next  [ENTRIES];
    len_t      prog_reg  [ENTRIES];
    len_t      prog_next [ENTRIES];
    slot_t     age_reg   [ENTRIES];
    slot_t     age_next  [ENTRIES];
    char_t     first_reg [ENTRIES];
    char_t     first_next[ENTRIES];
    len_t      load_count_reg, load_count_next;
    slot_t     load_slot_reg, load_slot_next;
    status_t   drop_reg, drop_next;
    slot_t     rd_idx_reg, rd_idx_next;
    logic      issue_reg, issue_next;
    logic      cmp_valid_reg, cmp_valid_next;
    logic      cmp_last_reg, cmp_last_next;
    slot_t     cmp_idx_reg, cmp_idx_next;
    logic      hit_reg, hit_next;
    slot_t     hit_age_reg, hit_age_next;
    key_t      hit_key_reg, hit_key_next;
    char_t     ch_reg, ch_next;
    mpbm_out_t res_reg, res_next;

    logic  ram_we, ram_re;
    addr_t ram_waddr, ram_raddr;
    char_t ram_wdata, ram_rdata;

    mpbm_char_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Writes happen only in idle, reads only in the sweep: ports never collide.
    always_comb begin
        char_t   ch_up;
        logic    free_found;
        slot_t   free_slot;
        slot_t   slot_eff;
        len_t    cnt;
        logic    done_load;
        logic    dup;
        logic    del_found;
        slot_t   del_slot;
        len_t    p;
        len_t    np;
        len_t    off;

        state_next      = state_reg;
        valid_next      = valid_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        prog_next       = prog_reg;
        age_next        = age_reg;
        first_next      = first_reg;
        load_count_next = load_count_reg;
        load_slot_next  = load_slot_reg;
        drop_next       = drop_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_last_next   = cmp_last_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_age_next    = hit_age_reg;
        hit_key_next    = hit_key_reg;
        ch_next         = ch_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        ch_up           = upcase(in_data.data_byte);
        free_found      = 1'b0;
        free_slot       = '0;
        slot_eff        = load_slot_reg;
        cnt             = load_count_reg;
        done_load       = 1'b0;
        dup             = 1'b0;
        del_found       = 1'b0;
        del_slot        = '0;
        p               = '0;
        np              = '0;
        off             = '0;

        for (int i = 0; i < ENTRIES; i++) begin
            if (!valid_reg[i] && !free_found) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
            if (valid_reg[i] && key_reg[i] == in_data.key) begin
                dup = 1'b1;
                if (!del_found) begin
                    del_found = 1'b1;
                    del_slot  = SLOT_W'(i);
                end
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    res_next   = '0;
                    state_next = S_DONE;
                    unique case (in_data.cmd)
                        CMD_MATCH: begin
                            ch_next = ch_up;
                            if (|valid_reg) begin
                                state_next  = S_SWEEP;
                                issue_next  = 1'b1;
                                rd_idx_next = '0;
                                hit_next    = 1'b0;
                            end
                        end
                        CMD_LOAD: begin
                            if (drop_reg != ST_OK) begin
                                res_next.status = drop_reg;
                                done_load       = 1'b1;
                                if (in_data.last) begin
                                    drop_next = ST_OK;
                                end
                            end else if (in_data.data_byte != 8'h00) begin
                                if (load_count_reg == '0) begin
                                    slot_eff = free_slot;
                                end
                                if (load_count_reg == '0 && !free_found) begin
                                    res_next.status = ST_FULL;
                                    done_load       = 1'b1;
                                    if (!in_data.last) begin
                                        drop_next = ST_FULL;
                                    end
                                end else if (load_count_reg >= LEN_W'(MAX_LEN)) begin
                                    load_count_next = '0;
                                    res_next.status = ST_TOO_LONG;
                                    done_load       = 1'b1;
                                    if (!in_data.last) begin
                                        drop_next = ST_TOO_LONG;
                                    end
                                end else begin
                                    load_slot_next = slot_eff;
                                    ram_we         = 1'b1;
                                    ram_waddr      = char_addr(slot_eff, load_count_reg);
                                    ram_wdata      = ch_up;
                                    if (load_count_reg == '0) begin
                                        first_next[slot_eff] = ch_up;
                                    end
                                    cnt             = load_count_reg + 1'b1;
                                    load_count_next = cnt;
                                end
                            end
                            if (!done_load && in_data.last) begin
                                load_count_next = '0;
                                if (cnt == '0 || in_data.key == '0) begin
                                    res_next.status = ST_IGNORED;
                                end else if (dup) begin
                                    res_next.status = ST_DUPLICATE;
                                end else begin
                                    for (int i = 0; i < ENTRIES; i++) begin
                                        if (valid_reg[i]) begin
                                            age_next[i] = age_reg[i] + 1'b1;
                                        end
                                    end
                                    valid_next[slot_eff] = 1'b1;
                                    key_next[slot_eff]   = in_data.key;
                                    len_next[slot_eff]   = cnt;
                                    prog_next[slot_eff]  = '0;
                                    age_next[slot_eff]   = '0;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (in_data.key == '0) begin
                                res_next.status = ST_IGNORED;
                            end else if (!del_found) begin
                                res_next.status = ST_NOT_FOUND;
                            end else begin
                                for (int j = 0; j < ENTRIES; j++) begin
                                    if (valid_reg[j] && age_reg[j] > age_reg[del_slot]) begin
                                        age_next[j] = age_reg[j] - 1'b1;
                                    end
                                end
                                valid_next[del_slot] = 1'b0;
                                prog_next[del_slot]  = '0;
                            end
                        end
                        CMD_CLEAR: begin
                            valid_next = '0;
                            for (int i = 0; i < ENTRIES; i++) begin
                                age_next[i]  = '0;
                                prog_next[i] = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (issue_reg) begin
                    p         = prog_reg[rd_idx_reg];
                    off       = (p < LEN_W'(MAX_LEN)) ? p : '0;
                    ram_re    = 1'b1;
                    ram_raddr = char_addr(rd_idx_reg, off);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg;
                    cmp_last_next  = (rd_idx_reg == LAST_SLOT);
                    if (rd_idx_reg == LAST_SLOT) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (cmp_valid_reg && valid_reg[cmp_idx_reg]) begin
                    p = prog_reg[cmp_idx_reg];
                    if (p < len_reg[cmp_idx_reg] && ch_reg == ram_rdata) begin
                        np = p + 1'b1;
                    end else if (ch_reg == first_reg[cmp_idx_reg]) begin
                        np = LEN_W'(1);
                    end else begin
                        np = '0;
                    end
                    prog_next[cmp_idx_reg] = np;
                    if (np >= len_reg[cmp_idx_reg] &&
                        (!hit_reg || age_reg[cmp_idx_reg] < hit_age_reg)) begin
                        hit_next     = 1'b1;
                        hit_age_next = age_reg[cmp_idx_reg];
                        hit_key_next = key_reg[cmp_idx_reg];
                    end
                end
                if (cmp_valid_reg && cmp_last_reg) begin
                    state_next         = S_DONE;
                    res_next.matched   = hit_next;
                    res_next.match_key = hit_next ? hit_key_next : '0;
                    res_next.status    = ST_OK;
                    if (hit_next) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            prog_next[i] = '0;
                        end
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            load_count_reg <= '0;
            load_slot_reg  <= '0;
            drop_reg       <= ST_OK;
            issue_reg      <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                prog_reg[i] <= '0;
                age_reg[i]  <= '0;
            end
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            load_count_reg <= load_count_next;
            load_slot_reg  <= load_slot_next;
            drop_reg       <= drop_next;
            issue_reg      <= issue_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_reg        <= hit_next;
            prog_reg       <= prog_next;
            age_reg        <= age_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        len_reg      <= len_next;
        first_reg    <= first_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_last_reg <= cmp_last_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_age_reg  <= hit_age_next;
        hit_key_reg  <= hit_key_next;
        ch_reg       <= ch_next;
        res_reg      <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data  = res_reg;

endmodule

[src/mpbm_checker.sv]
// Port-level checks on the matcher result channel, bound to the top level.
// Depends on mpbm_pkg and the assertion macro header.
`include "multi_pattern_byte_matcher_top_assert.svh"

module mpbm_checker
    import mpbm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input mpbm_out_t m_data
);

    `MPBM_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result word changed while stalled")
    `MPBM_ASSERT_IMP(a_match_ok, aclk, aresetn, m_valid && m_data.matched,
        m_data.status == ST_OK && m_data.match_key != '0, "match word with bad status or key")
    `MPBM_ASSERT_IMP(a_nomatch_key, aclk, aresetn, m_valid && !m_data.matched,
        m_data.match_key == '0, "key set without match")
    `MPBM_ASSERT_IMP(a_status_range, aclk, aresetn, m_valid,
        m_data.status <= ST_NOT_FOUND, "status code out of range")

endmodule

bind multi_pattern_byte_matcher_top mpbm_checker u_mpbm_checker (.*);

[test/testbench.sv]
// Testbench for multi_pattern_byte_matcher_top: directed table then random words,
// every result checked against a behavioural predictor of the pattern table.
// Depends on mpbm_pkg and the matcher RTL.
`timescale 1ns / 100ps

module testbench;
    import mpbm_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    mpbm_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    mpbm_out_t m_data;

    multi_pattern_byte_matcher_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // predictor state
    char_t  tbl_chars [ENTRIES*MAX_LEN];
    int     tbl_len   [ENTRIES];
    key_t   tbl_key   [ENTRIES];
    bit     tbl_used  [ENTRIES];
    int     tbl_prog  [ENTRIES];
    int     tbl_rank  [ENTRIES];
    int     ld_count, ld_slot;
    status_t ld_drop;

    mpbm_out_t pending_results[$];
    int   errors = 0;
    int   words_sent = 0, results_seen = 0, matches_seen = 0;
    int   idle_cycles = 0;
    bit   no_idle = 1'b0;
    int   rx_stall = 0;

    function automatic char_t fold(char_t c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic mpbm_out_t predict_word(mpbm_in_t w);
        mpbm_out_t r;
        char_t c;
        bit any, found, done;
        int p;
        r = '0;
        case (w.cmd)
            CMD_MATCH: begin
                c = fold(w.data_byte);
                any = 0;
                done = 0;
                for (int i = 0; i < ENTRIES; i++) any |= tbl_used[i];
                if (any) begin
                    for (int a = 0; a < ENTRIES && !done; a++) begin
                        for (int i = 0; i < ENTRIES && !done; i++) begin
                            if (tbl_used[i] && tbl_rank[i] == a) begin
                                p = tbl_prog[i];
                                if (p < tbl_len[i] && c == tbl_chars[i*MAX_LEN+p]) p++;
                                else if (c == tbl_chars[i*MAX_LEN]) p = 1;
                                else p = 0;
                                tbl_prog[i] = p;
                                if (p >= tbl_len[i]) begin
                                    r.matched = 1'b1;
                                    r.match_key = tbl_key[i];
                                    for (int j = 0; j < ENTRIES; j++) tbl_prog[j] = 0;
                                    done = 1;
                                end
                            end
                        end
                    end
                end
            end
            CMD_LOAD: begin
                if (ld_drop != ST_OK) begin
                    r.status = ld_drop;
                    if (w.last) ld_drop = ST_OK;
                    return r;
                end
                if (w.data_byte != 0) begin
                    if (ld_count == 0) begin
                        found = 0;
                        for (int i = 0; i < ENTRIES && !found; i++)
                            if (!tbl_used[i]) begin
                                ld_slot = i;
                                found = 1;
                            end
                        if (!found) begin
                            if (!w.last) ld_drop = ST_FULL;
                            r.status = ST_FULL;
                            return r;
                        end
                    end
                    if (ld_count >= MAX_LEN) begin
                        ld_count = 0;
                        if (!w.last) ld_drop = ST_TOO_LONG;
                        r.status = ST_TOO_LONG;
                        return r;
                    end
                    tbl_chars[ld_slot*MAX_LEN+ld_count] = fold(w.data_byte);
                    ld_count++;
                end
                if (!w.last) return r;
                p = ld_count;
                ld_count = 0;
                if (p == 0 || w.key == 0) begin
                    r.status = ST_IGNORED;
                    return r;
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_used[i] && tbl_key[i] == w.key) begin
                        r.status = ST_DUPLICATE;
                        return r;
                    end
                for (int i = 0; i < ENTRIES; i++) if (tbl_used[i]) tbl_rank[i]++;
                tbl_used[ld_slot] = 1;
                tbl_key[ld_slot] = w.key;
                tbl_len[ld_slot] = p;
                tbl_prog[ld_slot] = 0;
                tbl_rank[ld_slot] = 0;
            end
            CMD_DELETE: begin
                if (w.key == 0) begin
                    r.status = ST_IGNORED;
                    return r;
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_used[i] && tbl_key[i] == w.key) begin
                        for (int j = 0; j < ENTRIES; j++)
                            if (tbl_used[j] && tbl_rank[j] > tbl_rank[i]) tbl_rank[j]--;
                        tbl_used[i] = 0;
                        tbl_prog[i] = 0;
                        return r;
                    end
                r.status = ST_NOT_FOUND;
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    tbl_used[i] = 0;
                    tbl_rank[i] = 0;
                    tbl_prog[i] = 0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want,
                 results_seen);
    endtask

    // result side: random stalls, checking at the rising edge
    always @(posedge aclk) begin
        mpbm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_data, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.matched !== want.matched)
                    report_mismatch("matched", m_data.matched, want.matched);
                if (m_data.match_key !== want.match_key)
                    report_mismatch("match_key", m_data.match_key, want.match_key);
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
            end
            results_seen++;
            if (m_data.matched) matches_seen++;
        end
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles++;
        else idle_cycles = 0;
        if (idle_cycles >= 5000) begin
            $display("watchdog expired");
            $display("multi_pattern_byte_matcher_top verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(1, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(mpbm_in_t w);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge aclk);
        end
        @(negedge aclk);
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_word(w));
        words_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_word_known(mpbm_in_t w, bit known, mpbm_out_t want);
        mpbm_out_t p;
        @(negedge aclk);
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = predict_word(w);
        if (known && p !== want) report_mismatch("typed result", p, want);
        pending_results.push_back(p);
        words_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic mpbm_in_t mk(cmd_t c, key_t k, char_t d, logic l);
        mpbm_in_t w;
        w.cmd = c;
        w.key = k;
        w.data_byte = d;
        w.last = l;
        return w;
    endfunction

    function automatic mpbm_out_t res(logic m, key_t k, status_t s);
        mpbm_out_t r;
        r.matched = m;
        r.match_key = k;
        r.status = s;
        return r;
    endfunction

    typedef struct {
        mpbm_in_t  w;
        bit        known;
        mpbm_out_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    task automatic send_pattern(key_t k, int n, bit lower_alpha);
        char_t c;
        for (int i = 0; i < n; i++) begin
            c = lower_alpha ? char_t'($urandom_range(8'h41, 8'h44)) : char_t'($urandom);
            if (lower_alpha && $urandom_range(0, 1)) c = c | 8'h20;
            send_word(mk(CMD_LOAD, (i == n-1) ? k : key_t'($urandom), c, i == n-1));
        end
    endtask

    key_t kpool[8] = '{16'h0001, 16'h0002, 16'h00FF, 16'h1234, 16'h8000, 16'hFFFF,
                       16'h7FFF, 16'hA5A5};

    initial begin
        int r, n;
        mpbm_in_t w;
        for (int i = 0; i < ENTRIES*MAX_LEN; i++) tbl_chars[i] = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_len[i] = 0; tbl_key[i] = 0; tbl_used[i] = 0;
            tbl_prog[i] = 0; tbl_rank[i] = 0;
        end
        ld_count = 0; ld_slot = 0; ld_drop = ST_OK;

        dir_rows = '{
            '{mk(CMD_MATCH, 16'h0000, 8'h00, 1'b0), 1, res(0, 0, ST_OK)},
            '{mk(CMD_DELETE, 16'h0000, 8'h00, 1'b0), 1, res(0, 0, ST_IGNORED)},
            '{mk(CMD_DELETE, 16'hFFFF, 8'hFF, 1'b1), 1, res(0, 0, ST_NOT_FOUND)},
            '{mk(CMD_LOAD, 16'h0005, 8'h00, 1'b1), 1, res(0, 0, ST_IGNORED)},
            '{mk(CMD_LOAD, 16'h0000, 8'h61, 1'b0), 1, res(0, 0, ST_OK)},
            '{mk(CMD_LOAD, 16'h0000, 8'h7A, 1'b1), 1, res(0, 0, ST_IGNORED)},
            '{mk(CMD_LOAD, 16'h0000, 8'h61, 1'b0), 0, res(0, 0, ST_OK)},
            '{mk(CMD_LOAD, 16'h0000, 8'h00, 1'b0), 0, res(0, 0, ST_OK)},
            '{mk(CMD_DELETE, 16'h0009, 8'h00, 1'b0), 0, res(0, 0, ST_OK)},
            '{mk(CMD_LOAD, 16'hFFFF, 8'hFF, 1'b1), 1, res(0, 0, ST_OK)},
            '{mk(CMD_LOAD, 16'hFFFF, 8'h41, 1'b1), 1, res(0, 0, ST_DUPLICATE)},
            '{mk(CMD_MATCH, 16'h0000, 8'h61, 1'b0), 0, res(0, 0, ST_OK)},
            '{mk(CMD_MATCH, 16'hFFFF, 8'hFF, 1'b1), 0, res(0, 0, ST_OK)},
            '{mk(CMD_MATCH, 16'h0000, 8'h41, 1'b0), 0, res(0, 0, ST_OK)},
            '{mk(CMD_MATCH, 16'h0000, 8'h7A, 1'b0), 0, res(0, 0, ST_OK)},
            '{mk(CMD_DELETE, 16'hFFFF, 8'h00, 1'b0), 1, res(0, 0, ST_OK)},
            '{mk(CMD_CLEAR, 16'hFFFF, 8'hFF, 1'b1), 1, res(0, 0, ST_OK)},
            '{mk(CMD_MATCH, 16'h0000, 8'hFF, 1'b0), 1, res(0, 0, ST_OK)}
        };

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_word_known(dir_rows[i].w, dir_rows[i].known,
                                               dir_rows[i].want);
        // too long, then discarded tail
        for (int i = 0; i < MAX_LEN + 3; i++)
            send_word(mk(CMD_LOAD, 16'h0042, 8'h5A, i == MAX_LEN + 2));
        // full table, then discarded tail
        for (int k = 1; k <= ENTRIES; k++) send_pattern(key_t'(k), 2, 1'b1);
        send_word(mk(CMD_LOAD, 16'h0077, 8'h41, 1'b0));
        send_word(mk(CMD_LOAD, 16'h0077, 8'h42, 1'b1));
        send_word(mk(CMD_CLEAR, '0, '0, 1'b0));

        // hold off until the block has drained
        wait (pending_results.size() == 0);
        @(negedge aclk);

        for (int it = 0; it < 1150; ) begin
            if (it > 1000) no_idle = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 20) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34)
                                                 : $urandom_range(1, 4);
                send_pattern(kpool[$urandom_range(0, 7)], n, $urandom_range(0, 9) != 0);
                it += n;
            end else if (r < 75) begin
                w = mk(CMD_MATCH, key_t'($urandom), char_t'($urandom), 1'(($urandom)));
                if ($urandom_range(0, 3) != 0)
                    w.data_byte = char_t'($urandom_range(8'h41, 8'h44)
                                          | ($urandom_range(0, 1) << 5));
                send_word(w);
                it++;
            end else if (r < 90) begin
                send_word(mk(CMD_DELETE, $urandom_range(0, 5) ? kpool[$urandom_range(0, 7)]
                                                              : key_t'($urandom),
                             char_t'($urandom), 1'($urandom)));
                it++;
            end else if (r < 93) begin
                send_word(mk(CMD_CLEAR, key_t'($urandom), char_t'($urandom), 1'($urandom)));
                it++;
            end else begin
                send_word(mk(CMD_LOAD, key_t'($urandom), char_t'($urandom), 1'($urandom)));
                it++;
            end
        end
        no_idle = 1'b1;

        wait (pending_results.size() == 0);
        repeat (30) @(negedge aclk);
        $display("Ran %0d words giving %0d results, %0d of them pattern hits;", words_sent,
                 results_seen, matches_seen);
        $display("loads, deletes, clears, overflow and full-table cases were exercised.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("multi_pattern_byte_matcher_top verification clean");
        end else begin
            $display("multi_pattern_byte_matcher_top verification failed");
        end
        $finish;
    end
endmodule

[multi_pattern_byte_matcher_top.f]
+incdir+src
src/mpbm_pkg.sv
src/mpbm_char_ram.sv
src/mpbm_core.sv
src/multi_pattern_byte_matcher_top.sv
src/mpbm_checker.sv
test/testbench.sv
